// ===== hdl/idtp_pkg.sv =====
package idtp_pkg;

  // Parser phases, one-hot.
  typedef enum logic [3:0] {
    PH_TAG_HDR   = 4'b0001,
    PH_FRAME_HDR = 4'b0010,
    PH_PAYLOAD   = 4'b0100,
    PH_DONE      = 4'b1000
  } phase_e;

  // Result kinds as seen on the output port.
  typedef enum logic [1:0] {
    KIND_FRAME_START = 2'd0,
    KIND_VALUE       = 2'd1,
    KIND_TAG_END     = 2'd2
  } kind_e;

  // Configuration register indexes.
  localparam logic CFG_PREFIX_CHAR = 1'b0;
  localparam logic CFG_SKIP_COUNT  = 1'b1;

  // Header layout: ten bytes for the tag header and for each frame header.
  localparam logic [3:0] HDR_BYTES     = 4'd10;
  localparam logic [3:0] TAG_SIZE_BYTE = 4'd6;
  localparam logic [3:0] ID_END_BYTE   = 4'd4;
  localparam logic [3:0] SIZE_END_BYTE = 4'd8;

  localparam int unsigned TAG_LEN_W = 28;
  localparam int unsigned OFFSET_W  = 33;

  // Register reset values.
  localparam logic [7:0] PREFIX_RESET = 8'd84;
  localparam logic [3:0] SKIP_RESET   = 4'd3;

  // Output queue depth in items; each item carries one or two results.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // One queued item: a primary result, optionally followed by a tag end.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] ident;
    logic [7:0]  value;
    logic        has_end;
  } item_t;

endpackage

// ===== hdl/idtp_core.sv =====
module idtp_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [7:0]     cfg_data_i,
  input  logic           take_i,
  input  logic [7:0]     data_byte_i,
  input  logic           new_file_i,
  output logic           push_o,
  output idtp_pkg::item_t item_o
);
  import idtp_pkg::*;

  logic [7:0]           prefix_q;
  logic [3:0]           skip_q;
  phase_e               phase_q, phase_d;
  logic [3:0]           hbc_q, hbc_d;
  logic [TAG_LEN_W-1:0] tl_q, tl_d;
  logic [OFFSET_W-1:0]  off_q, off_d;
  logic [31:0]          flen_q, flen_d;
  logic [31:0]          pc_q, pc_d;
  logic [31:0]          ident_q, ident_d;
  logic                 sel_q, sel_d;

  phase_e               ph;
  logic [3:0]           hbc;
  logic [3:0]           hbc_inc;
  logic [31:0]          pc_inc;
  logic [OFFSET_W-1:0]  off_sum;
  logic                 bnd;
  logic [OFFSET_W-1:0]  off_cmp;
  logic                 tag_end;
  logic                 emit;
  kind_e                emit_kind;
  logic [7:0]           emit_value;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= PREFIX_RESET;
      skip_q   <= SKIP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PREFIX_CHAR: prefix_q <= cfg_data_i;
        CFG_SKIP_COUNT:  skip_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // A new file restarts at tag header byte 0. The length and ID registers
  // are fully shifted in again before use, so only phase and count restart.
  assign ph      = new_file_i ? PH_TAG_HDR : phase_q;
  assign hbc     = new_file_i ? 4'd0 : hbc_q;
  assign hbc_inc = hbc + 4'd1;
  assign pc_inc  = pc_q + 32'd1;

  // Per-byte state update and result selection.
  always_comb begin
    phase_d    = phase_q;
    hbc_d      = hbc_q;
    tl_d       = tl_q;
    off_d      = off_q;
    flen_d     = flen_q;
    pc_d       = pc_q;
    ident_d    = ident_q;
    sel_d      = sel_q;
    off_sum    = '0;
    bnd        = 1'b0;
    off_cmp    = off_q;
    emit       = 1'b0;
    emit_kind  = KIND_VALUE;
    emit_value = 8'd0;
    if (take_i) begin
      case (ph)
        PH_TAG_HDR: begin
          phase_d = PH_TAG_HDR;
          hbc_d   = hbc_inc;
          if (hbc >= TAG_SIZE_BYTE) begin
            tl_d = {tl_q[TAG_LEN_W-8:0], data_byte_i[6:0]};
          end
          if (hbc_inc >= HDR_BYTES) begin
            off_d   = '0;
            off_cmp = '0;
            bnd     = 1'b1;
          end
        end
        PH_FRAME_HDR: begin
          hbc_d = hbc_inc;
          if (hbc == 4'd0) begin
            sel_d = (data_byte_i == prefix_q);
          end
          if (hbc < ID_END_BYTE) begin
            ident_d = {ident_q[23:0], data_byte_i};
          end else if (hbc < SIZE_END_BYTE) begin
            flen_d = {flen_q[23:0], data_byte_i};
          end
          if (hbc_inc >= HDR_BYTES) begin
            emit      = sel_d;
            emit_kind = KIND_FRAME_START;
            off_sum   = off_q + {1'b0, flen_d} + OFFSET_W'(HDR_BYTES);
            off_d     = off_sum;
            off_cmp   = off_sum;
            pc_d      = '0;
            if (flen_d == 32'd0) begin
              bnd = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          emit       = sel_q && (pc_q >= {28'd0, skip_q});
          emit_kind  = KIND_VALUE;
          emit_value = data_byte_i;
          pc_d       = pc_inc;
          if (pc_inc >= flen_q) begin
            bnd = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Frame boundary: either the tag is finished or another frame follows.
    tag_end = bnd && (off_cmp >= {{(OFFSET_W-TAG_LEN_W){1'b0}}, tl_d});
    if (bnd) begin
      if (tag_end) begin
        phase_d = PH_DONE;
      end else begin
        phase_d = PH_FRAME_HDR;
        hbc_d   = 4'd0;
      end
    end
  end

  // Build the queued item; a lone tag end takes the primary slot.
  assign push_o         = emit || tag_end;
  assign item_o.kind    = emit ? emit_kind : KIND_TAG_END;
  assign item_o.ident   = emit ? ident_d : 32'd0;
  assign item_o.value   = emit ? emit_value : 8'd0;
  assign item_o.has_end = emit && tag_end;

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG_HDR;
      hbc_q   <= '0;
      tl_q    <= '0;
      off_q   <= '0;
      flen_q  <= '0;
      pc_q    <= '0;
      ident_q <= '0;
      sel_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hbc_q   <= hbc_d;
      tl_q    <= tl_d;
      off_q   <= off_d;
      flen_q  <= flen_d;
      pc_q    <= pc_d;
      ident_q <= ident_d;
      sel_q   <= sel_d;
    end
  end

  // A two-result item always closes the tag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && item_o.has_end) |=> (phase_q == PH_DONE))
    else $error("two-result item did not end the tag");

  // Once done, the parser stays done until a new file starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE && !(take_i && new_file_i)) |=> (phase_q == PH_DONE))
    else $error("parser left done phase without a new file");

  // Value bytes are only produced in the payload phase of a selected frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && item_o.kind == KIND_VALUE) |-> (sel_q && !new_file_i))
    else $error("value byte from an unselected frame");

endmodule

// ===== hdl/idtp_outq.sv =====
module idtp_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  idtp_pkg::item_t item_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      kind_o,
  output logic [31:0]     frame_ident_o,
  output logic [7:0]      value_byte_o,
  output logic            last_of_run_o
);
  import idtp_pkg::*;

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              sub_q;
  item_t             head;
  logic              pop;
  logic              adv;

  assign head        = mem_q[rd_ptr_q];
  assign ready_o     = (cnt_q != QCNT_W'(QDEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  // The head item retires after its last result is transferred.
  assign adv         = pop && (sub_q || !head.has_end);

  // Present the primary result, then the trailing tag end if there is one.
  always_comb begin
    if (sub_q) begin
      kind_o        = KIND_TAG_END;
      frame_ident_o = 32'd0;
      value_byte_o  = 8'd0;
      last_of_run_o = 1'b1;
    end else begin
      kind_o        = head.kind;
      frame_ident_o = head.ident;
      value_byte_o  = head.value;
      last_of_run_o = !head.has_end;
    end
  end

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers, fill count and result index within the head item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      sub_q    <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (adv) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
        sub_q    <= 1'b0;
      end else if (pop) begin
        sub_q    <= 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(adv);
    end
  end

  // No item is written into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != QCNT_W'(QDEPTH)))
    else $error("push into full output queue");

  // The second result is only pending for an item that carries a tag end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (out_valid_o && head.has_end))
    else $error("pending tag end without a two-result item");

  // A transfer that is not last is followed by the tag end of the same item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !last_of_run_o) |=> (out_valid_o && kind_o == KIND_TAG_END && last_of_run_o))
    else $error("missing tag end after first result of a run");

endmodule

// ===== hdl/id3v2_text_frame_parser.sv =====
// Streaming tag parser: takes one file byte per cycle on the input channel and
// emits frame-start, value-byte and tag-end results for frames whose ID begins
// with the configured character. Each byte is handled in the cycle it is
// transferred, so the input sustains one byte per clock. Results leave through
// a two-item queue, one result per cycle while out_ready_i is high; a byte that
// yields two results (an emitted last payload byte of a selected frame, or the
// header of a selected zero-size frame, when the tag also ends there) leaves as
// two transfers. The input only stalls when the queue holds two items whose
// results have not all been transferred yet.
// Configuration writes take effect at once and are meant for idle periods.
module id3v2_text_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        new_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] frame_ident_o,
  output logic [7:0]  value_byte_o,
  output logic        last_of_run_o
);
  import idtp_pkg::*;

  logic  take;
  logic  push;
  item_t item;

  // A byte is processed in the cycle of its transfer.
  assign take = in_valid_i && in_ready_o;

  idtp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .data_byte_i (data_byte_i),
    .new_file_i  (new_file_i),
    .push_o      (push),
    .item_o      (item)
  );

  idtp_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .item_i        (item),
    .ready_o       (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .frame_ident_o (frame_ident_o),
    .value_byte_o  (value_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
